FILE: rtl/inflight_range_race_detector_top_assert.svh
// Assertion macros used by the slot table of the range race detector RTL.
`ifndef INFLIGHT_RANGE_RACE_DETECTOR_TOP_ASSERT_SVH
`define INFLIGHT_RANGE_RACE_DETECTOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define IRRD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("irrd: assertion failed");
`define IRRD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irrd: implication failed");
`else
`define IRRD_ASSERT(label, prop)
`define IRRD_ASSERT_IMP(label, ante, cons)
`endif
`endif

FILE: rtl/irrd_pkg.sv
// Types, constants and helpers for the in-flight range race detector.
`timescale 1ns / 1ps
package irrd_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int INDEX_BITS    = 48;

    localparam int FIELD_W     = 48;
    localparam int COUNT_W     = 16;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int MASK_W      = 16;
    localparam int RACE_W      = 5;
    localparam int CFG_INDEX_W = 1;
    localparam int SLOT_W      = $clog2(TABLE_ENTRIES);
    localparam int CNT_W       = $clog2(TABLE_ENTRIES + 1);
    localparam int MASK_SLOTS  = (TABLE_ENTRIES < MASK_W) ? TABLE_ENTRIES : MASK_W;

    localparam logic [INDEX_BITS-1:0] IDX_MAX          = '1;
    localparam logic [FIELD_W-1:0]    WINDOW_END_RESET = FIELD_W'(IDX_MAX);
    localparam logic [KIND_W-1:0]     KIND_READ        = '0;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK,
        STATUS_IGNORED,
        STATUS_FULL,
        STATUS_NOT_FOUND
    } status_t;

    typedef enum logic {
        ACT_ENTER,
        ACT_LEAVE
    } action_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WINDOW_BEGIN,
        REG_WINDOW_END
    } cfg_reg_t;

    typedef struct packed {
        logic               action;
        logic [FIELD_W-1:0] start_block;
        logic [COUNT_W-1:0] block_count;
        logic [KIND_W-1:0]  range_kind;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  clipped_begin;
        logic [FIELD_W-1:0]  clipped_end;
        logic [MASK_W-1:0]   conflict_mask;
        logic [RACE_W-1:0]   mixed_races;
        logic [RACE_W-1:0]   same_kind_races;
        logic [RACE_W-1:0]   occupancy;
    } rsp_t;

    // Clipped request handed from the clip stage to the table stage.
    typedef struct packed {
        logic                  action;
        logic [KIND_W-1:0]     kind;
        logic                  ignore;
        logic [INDEX_BITS-1:0] cb;
        logic [INDEX_BITS-1:0] ce;
    } clip_t;

    function automatic logic [RACE_W-1:0] sat5(input logic [CNT_W-1:0] v);
        if (32'(v) > 32'd31)
            return RACE_W'(31);
        else
            return RACE_W'(v);
    endfunction

endpackage

FILE: rtl/inflight_range_race_detector_top.sv
// Top level of the in-flight range race detector.
`timescale 1ns / 1ps
// Tracks up to 16 in-flight block ranges and reports, for each enter, which
// stored ranges race with it, and frees the exact matching entry on a leave.
// One beat is taken every cycle unless rsp_ready holds the output; a result
// passes the clip register, then the result register. The parallel compare
// and update over all table slots follow one stage after the range end and
// window clipping. The user must write window registers through cfg_we/
// cfg_index/cfg_data only while idle; the block does not enforce it.
module inflight_range_race_detector_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  irrd_pkg::req_t                   req,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output irrd_pkg::rsp_t                   rsp,
    input  logic                             cfg_we,
    input  logic [irrd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [irrd_pkg::FIELD_W-1:0]     cfg_data
);
    import irrd_pkg::*;

    logic [FIELD_W-1:0] window_begin_reg;
    logic [FIELD_W-1:0] window_end_reg;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rsp_t               rsp_reg;
    rsp_t               table_rsp;
    clip_t              clip;
    logic               clip_valid;
    logic               out_adv;
    logic               drain;
    logic               load;

    assign out_adv   = !rsp_valid_reg || rsp_ready;
    assign drain     = clip_valid && out_adv;
    assign req_ready = !clip_valid || out_adv;
    assign load      = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_begin_reg <= '0;
            window_end_reg   <= WINDOW_END_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_BEGIN: window_begin_reg <= cfg_data;
                REG_WINDOW_END:   window_end_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    irrd_clip u_clip (
        .clk          (clk),
        .rst_n        (rst_n),
        .window_begin (window_begin_reg),
        .window_end   (window_end_reg),
        .load         (load),
        .drain        (drain),
        .req          (req),
        .valid        (clip_valid),
        .clip         (clip)
    );

    irrd_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (drain),
        .clip  (clip),
        .rsp   (table_rsp)
    );

    always_comb
    begin
        if (drain)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (drain)
            rsp_reg <= table_rsp;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: rtl/irrd_clip.sv
// Clip stage: computes the request's end, clips it to the window, registers the beat.
`timescale 1ns / 1ps
module irrd_clip (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [irrd_pkg::FIELD_W-1:0] window_begin,
    input  logic [irrd_pkg::FIELD_W-1:0] window_end,
    input  logic                    load,
    input  logic                    drain,
    input  irrd_pkg::req_t          req,
    output logic                    valid,
    output irrd_pkg::clip_t         clip
);
    import irrd_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    clip_t                 clip_reg;
    clip_t                 clip_next;
    logic [INDEX_BITS-1:0] wb;
    logic [INDEX_BITS-1:0] we;
    logic [INDEX_BITS-1:0] rb;
    logic [INDEX_BITS-1:0] re;
    logic [COUNT_W-1:0]    len_m1;
    logic [INDEX_BITS:0]   sum;

    always_comb
    begin
        wb     = INDEX_BITS'(window_begin);
        we     = INDEX_BITS'(window_end);
        rb     = INDEX_BITS'(req.start_block);
        len_m1 = req.block_count - COUNT_W'(1);
        sum    = {1'b0, rb} + (INDEX_BITS + 1)'(len_m1);
        re     = sum[INDEX_BITS] ? IDX_MAX : sum[INDEX_BITS-1:0];

        clip_next.action = req.action;
        clip_next.kind   = req.range_kind;
        clip_next.ignore = (req.block_count == '0) || (wb > we) || !((rb <= we) && (wb <= re));
        clip_next.cb     = (rb > wb) ? rb : wb;
        clip_next.ce     = (re < we) ? re : we;

        if (load)
            valid_next = 1'b1;
        else if (drain)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            clip_reg <= clip_next;
    end

    assign valid = valid_reg;
    assign clip  = clip_reg;

endmodule

FILE: rtl/irrd_table.sv
// Slot table: parallel overlap and match compare, free-slot pick and update.
`timescale 1ns / 1ps
`include "inflight_range_race_detector_top_assert.svh"
module irrd_table (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  irrd_pkg::clip_t clip,
    output irrd_pkg::rsp_t  rsp
);
    import irrd_pkg::*;

    logic [TABLE_ENTRIES-1:0] slot_valid_reg;
    logic [TABLE_ENTRIES-1:0] slot_valid_next;
    logic [INDEX_BITS-1:0]    slot_begin_reg [TABLE_ENTRIES];
    logic [INDEX_BITS-1:0]    slot_end_reg   [TABLE_ENTRIES];
    logic [KIND_W-1:0]        slot_kind_reg  [TABLE_ENTRIES];
    logic [CNT_W-1:0]         occ_reg;
    logic [CNT_W-1:0]         occ_next;

    logic [TABLE_ENTRIES-1:0] race;
    logic [TABLE_ENTRIES-1:0] differ;
    logic [TABLE_ENTRIES-1:0] hit;
    logic [SLOT_W-1:0]        free_idx;
    logic [SLOT_W-1:0]        hit_idx;
    logic                     free_any;
    logic                     hit_any;
    logic                     store_en;
    logic                     clear_en;

    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            race[i] = slot_valid_reg[i]
                      && (clip.cb <= slot_end_reg[i]) && (slot_begin_reg[i] <= clip.ce)
                      && !((clip.kind == KIND_READ) && (slot_kind_reg[i] == KIND_READ));
            differ[i] = slot_kind_reg[i] != clip.kind;
            hit[i]    = slot_valid_reg[i] && (slot_begin_reg[i] == clip.cb)
                        && (slot_end_reg[i] == clip.ce) && (slot_kind_reg[i] == clip.kind);
        end

        free_idx = '0;
        hit_idx  = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i])
                free_idx = SLOT_W'(i);
            if (hit[i])
                hit_idx = SLOT_W'(i);
        end
        free_any = !(&slot_valid_reg);
        hit_any  = |hit;

        store_en        = 1'b0;
        clear_en        = 1'b0;
        slot_valid_next = slot_valid_reg;
        occ_next        = occ_reg;
        rsp             = '0;
        rsp.status      = STATUS_OK;

        if (clip.ignore)
        begin
            rsp.status = STATUS_IGNORED;
        end
        else
        begin
            rsp.clipped_begin = FIELD_W'(clip.cb);
            rsp.clipped_end   = FIELD_W'(clip.ce);
            if (clip.action == ACT_ENTER)
            begin
                for (int i = 0; i < MASK_SLOTS; i++)
                    rsp.conflict_mask[i] = race[i];
                rsp.mixed_races     = sat5(CNT_W'($countones(race & differ)));
                rsp.same_kind_races = sat5(CNT_W'($countones(race & ~differ)));
                if (free_any)
                begin
                    store_en                  = 1'b1;
                    slot_valid_next[free_idx] = 1'b1;
                    occ_next                  = occ_reg + CNT_W'(1);
                end
                else
                begin
                    rsp.status = STATUS_FULL;
                end
            end
            else if (hit_any)
            begin
                clear_en                 = 1'b1;
                slot_valid_next[hit_idx] = 1'b0;
                occ_next                 = occ_reg - CNT_W'(1);
            end
            else
            begin
                rsp.status = STATUS_NOT_FOUND;
            end
        end
        rsp.occupancy = sat5(occ_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            occ_reg        <= '0;
        end
        else if (fire)
        begin
            slot_valid_reg <= slot_valid_next;
            occ_reg        <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && store_en)
        begin
            slot_begin_reg[free_idx] <= clip.cb;
            slot_end_reg[free_idx]   <= clip.ce;
            slot_kind_reg[free_idx]  <= clip.kind;
        end
    end

    `IRRD_ASSERT(a_occ_matches_valid, occ_reg == CNT_W'($countones(slot_valid_reg)))
    `IRRD_ASSERT_IMP(a_full_only_when_full, rsp.status == STATUS_FULL, &slot_valid_reg)
    `IRRD_ASSERT(a_store_bumps_occ, fire && store_en |=> occ_reg == $past(occ_reg) + CNT_W'(1))
    `IRRD_ASSERT(a_leave_frees_slot, fire && clear_en |=> !slot_valid_reg[$past(hit_idx)])

endmodule

FILE: test/inflight_range_race_detector_top_tb.sv
// Testbench for the in-flight range race detector: random and directed beats checked against a predictor.
`timescale 1ns / 1ps
module inflight_range_race_detector_top_tb;
    import irrd_pkg::*;

    localparam logic [FIELD_W-1:0] LAST_BLOCK  = '1;
    localparam logic [KIND_W-1:0]  KIND_WRITE  = 2'd1;
    localparam logic [KIND_W-1:0]  KIND_ZERO   = 2'd2;
    localparam logic [KIND_W-1:0]  KIND_SPARE  = 2'd3;
    localparam int                 STALL_LIMIT = 3000;
    localparam int                 HOLD_CYCLES = 80;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    req_t                   req       = '0;
    logic                   rsp_valid;
    logic                   rsp_ready = 1'b0;
    rsp_t                   rsp;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [FIELD_W-1:0]     cfg_data  = '0;

    // predictor copy of the window and the slot table
    logic [FIELD_W-1:0] win_begin = '0;
    logic [FIELD_W-1:0] win_end   = LAST_BLOCK;
    bit                 slot_used [TABLE_ENTRIES];
    logic [FIELD_W-1:0] slot_lo   [TABLE_ENTRIES];
    logic [FIELD_W-1:0] slot_hi   [TABLE_ENTRIES];
    logic [KIND_W-1:0]  slot_kind [TABLE_ENTRIES];

    req_t pending_req [$];
    req_t live_ranges [$];
    rsp_t expected_rsp [$];

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_left;
    int rsp_total;
    int fail_count;
    int race_total;
    int status_seen [4];
    int stall_cycles;

    inflight_range_race_detector_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10;
        clk = 1'b1;
        #10;
        clk = 1'b0;
    end

    function automatic rsp_t predict_step(req_t r);
        rsp_t               o;
        logic [63:0]        span;
        logic [FIELD_W-1:0] re;
        logic [FIELD_W-1:0] cb;
        logic [FIELD_W-1:0] ce;
        int                 free_slot;
        int                 mixed;
        int                 same;
        int                 used;
        o = '0;
        free_slot = -1;
        mixed = 0;
        same = 0;
        used = 0;
        span = 64'(r.block_count) - 64'd1;
        if (r.block_count == '0 || win_begin > win_end)
        begin
            o.status = STATUS_IGNORED;
        end
        else
        begin
            if (span > 64'(LAST_BLOCK - r.start_block))
                re = LAST_BLOCK;
            else
                re = r.start_block + span[FIELD_W-1:0];
            if (r.start_block > win_end || re < win_begin)
            begin
                o.status = STATUS_IGNORED;
            end
            else
            begin
                cb = (r.start_block > win_begin) ? r.start_block : win_begin;
                ce = (re < win_end) ? re : win_end;
                o.clipped_begin = cb;
                o.clipped_end = ce;
                if (r.action == ACT_ENTER)
                begin
                    o.status = STATUS_OK;
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                    begin
                        if (!slot_used[i])
                        begin
                            if (free_slot < 0)
                                free_slot = i;
                        end
                        else if (cb <= slot_hi[i] && slot_lo[i] <= ce &&
                                 !(r.range_kind == KIND_READ && slot_kind[i] == KIND_READ))
                        begin
                            if (slot_kind[i] != r.range_kind)
                                mixed++;
                            else
                                same++;
                            if (i < MASK_W)
                                o.conflict_mask[i] = 1'b1;
                        end
                    end
                    if (free_slot < 0)
                    begin
                        o.status = STATUS_FULL;
                    end
                    else
                    begin
                        slot_used[free_slot] = 1'b1;
                        slot_lo[free_slot]   = cb;
                        slot_hi[free_slot]   = ce;
                        slot_kind[free_slot] = r.range_kind;
                    end
                end
                else
                begin
                    o.status = STATUS_NOT_FOUND;
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                    begin
                        if (o.status == STATUS_NOT_FOUND && slot_used[i] &&
                            slot_lo[i] == cb && slot_hi[i] == ce &&
                            slot_kind[i] == r.range_kind)
                        begin
                            slot_used[i] = 1'b0;
                            o.status = STATUS_OK;
                        end
                    end
                end
            end
        end
        for (int i = 0; i < TABLE_ENTRIES; i++)
            used += slot_used[i];
        o.mixed_races     = (mixed > 31) ? 5'd31 : RACE_W'(mixed);
        o.same_kind_races = (same > 31) ? 5'd31 : RACE_W'(same);
        o.occupancy       = (used > 31) ? 5'd31 : RACE_W'(used);
        race_total += mixed + same;
        status_seen[o.status]++;
        return o;
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    // driver: one request beat per handshake, prediction taken at acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else if (!req_valid || req_ready)
        begin
            if (req_valid)
                expected_rsp.insert(expected_rsp.size(), predict_step(req));
            if (pending_req.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                req <= pending_req.pop_front();
                req_valid <= 1'b1;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // monitor: checks response beats, throttles rsp_ready, long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                rsp_total++;
                if (expected_rsp.size() == 0)
                begin
                    $error("response beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    rsp_t e;
                    e = expected_rsp.pop_front();
                    check_field("status", 64'(e.status), 64'(rsp.status));
                    check_field("clipped_begin", 64'(e.clipped_begin),
                                64'(rsp.clipped_begin));
                    check_field("clipped_end", 64'(e.clipped_end), 64'(rsp.clipped_end));
                    check_field("conflict_mask", 64'(e.conflict_mask),
                                64'(rsp.conflict_mask));
                    check_field("mixed_races", 64'(e.mixed_races), 64'(rsp.mixed_races));
                    check_field("same_kind_races", 64'(e.same_kind_races),
                                64'(rsp.same_kind_races));
                    check_field("occupancy", 64'(e.occupancy), 64'(rsp.occupancy));
                end
                if (rsp_total == 120 || rsp_total == 700)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_we)
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", stall_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    function automatic logic [FIELD_W-1:0] random_block();
        return FIELD_W'({$urandom, $urandom});
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        int roll;
        roll = $urandom_range(99);
        if (roll < 4)
            return '0;
        else if (roll < 10)
            return COUNT_W'($urandom);
        else
            return COUNT_W'($urandom_range(64, 1));
    endfunction

    task automatic send(input action_t act, input logic [FIELD_W-1:0] start,
                        input logic [COUNT_W-1:0] cnt, input logic [KIND_W-1:0] kind);
        req_t r;
        r.action      = act;
        r.start_block = start;
        r.block_count = cnt;
        r.range_kind  = kind;
        pending_req.insert(pending_req.size(), r);
        if (act == ACT_ENTER)
            live_ranges.insert(live_ranges.size(), r);
    endtask

    task automatic send_leave_live();
        int   k;
        req_t r;
        k = $urandom_range(live_ranges.size() - 1);
        r = live_ranges[k];
        live_ranges.delete(k);
        r.action = ACT_LEAVE;
        pending_req.insert(pending_req.size(), r);
    endtask

    // mostly enter/leave pairs in a hot area, some noise and wrong-kind leaves
    task automatic run_random(int n_items, logic [FIELD_W-1:0] area_lo, int area_span,
                              int live_cap);
        int   roll;
        req_t r;
        for (int n = 0; n < n_items; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 8)
            begin
                send(action_t'($urandom_range(1)), random_block(), COUNT_W'($urandom),
                     KIND_W'($urandom));
            end
            else if (roll < 12 && live_ranges.size() != 0)
            begin
                r = live_ranges[$urandom_range(live_ranges.size() - 1)];
                r.action = ACT_LEAVE;
                r.range_kind = r.range_kind ^ KIND_W'($urandom_range(3, 1));
                pending_req.insert(pending_req.size(), r);
            end
            else if (live_ranges.size() != 0 && (roll < 52 || live_ranges.size() >= live_cap))
            begin
                send_leave_live();
            end
            else
            begin
                send(ACT_ENTER, area_lo + FIELD_W'($urandom_range(area_span)), pick_count(),
                     KIND_W'($urandom_range(3)));
            end
        end
        while (live_ranges.size() != 0)
            send_leave_live();
    endtask

    task automatic wait_idle();
        while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [FIELD_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_WINDOW_BEGIN)
            win_begin = val;
        else
            win_end = val;
    endtask

    task automatic set_window(input logic [FIELD_W-1:0] lo, input logic [FIELD_W-1:0] hi);
        write_reg(REG_WINDOW_BEGIN, lo);
        write_reg(REG_WINDOW_END, hi);
    endtask

    initial
    begin
        tx_idle_pct = 35;
        rx_idle_pct = 61;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: overlaps between kinds, zero count, saturation, leave misses
        send(ACT_ENTER, 48'd100, 16'd10, KIND_WRITE);
        send(ACT_ENTER, 48'd105, 16'd10, KIND_READ);
        send(ACT_ENTER, 48'd100, 16'd1, KIND_READ);
        send(ACT_ENTER, 48'd109, 16'd1, KIND_WRITE);
        send(ACT_ENTER, 48'd0, 16'hFFFF, KIND_ZERO);
        send(ACT_ENTER, 48'd107, 16'd2, KIND_SPARE);
        send(ACT_ENTER, 48'd50, 16'd0, KIND_READ);
        send(ACT_ENTER, LAST_BLOCK, 16'hFFFF, KIND_WRITE);
        send(ACT_ENTER, LAST_BLOCK - 48'd10, 16'd16, KIND_ZERO);
        send(ACT_LEAVE, 48'd100, 16'd10, KIND_READ);
        send(ACT_LEAVE, 48'd100, 16'd10, KIND_WRITE);
        send(ACT_LEAVE, 48'd100, 16'd10, KIND_WRITE);
        send(ACT_LEAVE, 48'd5, 16'd0, KIND_READ);
        send(ACT_ENTER, 48'h5555_5555_5555, 16'hAAAA, KIND_WRITE);
        send(ACT_ENTER, 48'hAAAA_AAAA_AAAA, 16'h5555, KIND_READ);
        send(ACT_LEAVE, LAST_BLOCK, 16'd1, KIND_WRITE);

        run_random(200, 48'h0000_1234_0000, 600, 20);
        wait_idle();

        set_window(48'd1000, 48'd1300);
        run_random(200, 48'd900, 500, 14);
        wait_idle();

        tx_idle_pct = 61;
        rx_idle_pct = 35;
        set_window(LAST_BLOCK, LAST_BLOCK);
        run_random(100, LAST_BLOCK - 48'd64, 64, 18);
        wait_idle();

        set_window('0, '0);
        run_random(60, '0, 40, 18);
        wait_idle();

        // begin after end: every range is dropped
        set_window(48'd5000, 48'd10);
        run_random(40, '0, 6000, 16);
        wait_idle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_window('0, LAST_BLOCK);
        run_random(250, 48'h8000_0000_0000, 800, 18);
        wait_idle();
        repeat (10) @(posedge clk);

        $display("Covered %0d request beats over six windows and three idling modes",
                 rsp_total);
        $display("  %0d races, %0d table-full, %0d leave misses, %0d dropped ranges",
                 race_total, status_seen[STATUS_FULL], status_seen[STATUS_NOT_FOUND],
                 status_seen[STATUS_IGNORED]);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/irrd_pkg.sv
rtl/irrd_clip.sv
rtl/irrd_table.sv
rtl/inflight_range_race_detector_top.sv
test/inflight_range_race_detector_top_tb.sv
